/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the decimal formatter.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/udf_pkg.sv */
// Package for the unsigned decimal formatter: payload structs, constants and
// the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package udf_pkg;

  localparam int VALUE_W    = 64;
  localparam int LEN_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int MAX_FIELD  = 63;
  localparam int MAX_DIGITS = 20;
  localparam int BCD_W      = 4 * MAX_DIGITS;
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // Shift-and-add-3 correction for radix ten digits.
  localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [3:0] DIGIT_ADJ     = 4'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   field_width;
    logic [LEN_W-1:0]   min_digits;
    logic               left_align;
    logic               zero_pad_flag;
    logic               precision_given;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic [LEN_W-1:0]  total_length;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } udf_state_t;

endpackage

/* rtl/core/udf_bcd_step.sv */
// One shift-and-add-3 step of binary to BCD conversion over all digits.
// Depends on udf_pkg.
`timescale 1ns / 1ps

module udf_bcd_step
  import udf_pkg::*;
(
  input  logic [BCD_W-1:0] bcd_in,
  input  logic             bit_in,
  output logic [BCD_W-1:0] bcd_out
);

  logic [BCD_W-1:0] adjusted;

  // Every digit of five or more gets three added so that the shift carries
  // correctly into the next digit.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_in[4*i +: 4] >= DIGIT_ADJ_MIN) begin
        adjusted[4*i +: 4] = bcd_in[4*i +: 4] + DIGIT_ADJ;
      end else begin
        adjusted[4*i +: 4] = bcd_in[4*i +: 4];
      end
    end
  end

  assign bcd_out = {adjusted[BCD_W-2:0], bit_in};

endmodule

/* rtl/core/unsigned_decimal_formatter_top.sv */
// Top level of the unsigned decimal formatter: sequencer, padding logic and
// output register. Depends on udf_pkg, udf_bcd_step and assert_macros.svh.
`timescale 1ns / 1ps

// Formats one 64-bit unsigned value per transaction as printf-style decimal
// text and sends it out one ASCII character per output transaction, each
// carrying the run length and a last flag on the final character. A value
// is converted by one shared shift-and-add-3 BCD step unit, applied to each
// value bit in turn; then leading zero digits are stripped one digit per
// cycle until the leading digit is found, the padding boundaries are set up,
// and the run leaves at one character per cycle while the output is not
// stalled. From the accepting edge in_stall stays high until the last
// character of the run is taken into the output register, output stalls
// included. A zero value with the dot flag, precision zero and width zero
// gives no output at all. The last character may still wait in the output
// register while the next input transaction is accepted.
module unsigned_decimal_formatter_top
  import udf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "assert_macros.svh"

  udf_state_t state_r, state_nxt;

  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt, bcd_step;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [NDIG_W-1:0]    ndig_r, ndig_nxt;

  // Formatting request held for the length of the item.
  logic [LEN_W-1:0] width_r, width_nxt;
  logic [LEN_W-1:0] prec_r, prec_nxt;
  logic             minus_r, minus_nxt;
  logic             zflag_r, zflag_nxt;
  logic             dot_r, dot_nxt;

  // Region boundaries of the run: lead pad ends at b1, precision zeros at
  // b2, digits at b3; trailing spaces fill the rest up to total.
  logic [LEN_W-1:0] b1_r, b1_nxt;
  logic [LEN_W-1:0] b2_r, b2_nxt;
  logic [LEN_W-1:0] b3_r, b3_nxt;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic             pad_zero_r, pad_zero_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic in_accept;
  logic out_free;
  logic emit_now;
  logic emit_last;
  logic top_zero;

  // Setup arithmetic.
  logic [LEN_W-1:0] width_sat, prec_sat, nd_eff, sum_nz, total_c;
  logic [LEN_W-1:0] zeros_c, pad_c, b1_c;

  logic [CHAR_W-1:0] char_c;

  udf_bcd_step u_bcd_step (
    .bcd_in  (bcd_r),
    .bit_in  (bin_r[VALUE_W-1]),
    .bcd_out (bcd_step)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_now  = (state_r == ST_EMIT) && out_free;
  assign emit_last = (pos_r == total_r - 6'd1);
  assign top_zero  = (bcd_r[BCD_W-1 -: 4] == 4'd0);

  // Padding arithmetic from the stripped digit count.
  always_comb begin
    width_sat = (width_r > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : width_r;
    prec_sat  = (prec_r > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : prec_r;
    if (ndig_r != '0) begin
      nd_eff = LEN_W'(ndig_r);
    end else if (dot_r && (prec_sat == '0)) begin
      nd_eff = '0;
    end else begin
      nd_eff = 6'd1;
    end
    sum_nz  = (prec_sat > nd_eff) ? prec_sat : nd_eff;
    total_c = (width_sat > sum_nz) ? width_sat : sum_nz;
    zeros_c = sum_nz - nd_eff;
    pad_c   = total_c - sum_nz;
    b1_c    = minus_r ? '0 : pad_c;
  end

  // Character at the current position of the run.
  always_comb begin
    if (pos_r < b1_r) begin
      char_c = pad_zero_r ? CH_ZERO : CH_SPACE;
    end else if (pos_r < b2_r) begin
      char_c = CH_ZERO;
    end else if (pos_r < b3_r) begin
      char_c = CH_ZERO + {4'd0, bcd_r[BCD_W-1 -: 4]};
    end else begin
      char_c = CH_SPACE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == '1) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if ((ndig_r == '0) || !top_zero) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = (total_c == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_now && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  // Datapath next values.
  always_comb begin
    bin_nxt      = bin_r;
    bcd_nxt      = bcd_r;
    bit_cnt_nxt  = bit_cnt_r;
    ndig_nxt     = ndig_r;
    width_nxt    = width_r;
    prec_nxt     = prec_r;
    minus_nxt    = minus_r;
    zflag_nxt    = zflag_r;
    dot_nxt      = dot_r;
    b1_nxt       = b1_r;
    b2_nxt       = b2_r;
    b3_nxt       = b3_r;
    total_nxt    = total_r;
    pad_zero_nxt = pad_zero_r;
    pos_nxt      = pos_r;
    out_data_nxt = out_data_r;

    if (state_r == ST_IDLE && in_accept) begin
      bin_nxt     = in_data.value;
      bcd_nxt     = '0;
      bit_cnt_nxt = '0;
      ndig_nxt    = NDIG_W'(MAX_DIGITS);
      width_nxt   = in_data.field_width;
      prec_nxt    = in_data.min_digits;
      minus_nxt   = in_data.left_align;
      zflag_nxt   = in_data.zero_pad_flag;
      dot_nxt     = in_data.precision_given;
    end

    if (state_r == ST_CONV) begin
      bcd_nxt     = bcd_step;
      bin_nxt     = {bin_r[VALUE_W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end

    // Strip leading zero digits so the top digit is the first to print.
    if (state_r == ST_NORM && ndig_r != '0 && top_zero) begin
      bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
      ndig_nxt = ndig_r - 1'b1;
    end

    if (state_r == ST_SETUP) begin
      b1_nxt       = b1_c;
      b2_nxt       = b1_c + zeros_c;
      b3_nxt       = b1_c + zeros_c + nd_eff;
      total_nxt    = total_c;
      pad_zero_nxt = zflag_r && !dot_r && !minus_r;
      pos_nxt      = '0;
    end

    if (emit_now) begin
      out_data_nxt.character    = char_c;
      out_data_nxt.total_length = total_r;
      out_data_nxt.last         = emit_last;
      pos_nxt                   = pos_r + 1'b1;
      if (pos_r >= b2_r && pos_r < b3_r) begin
        bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
      end
    end
  end

  always_comb begin
    if (emit_now) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      bit_cnt_r   <= '0;
      ndig_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      ndig_r      <= ndig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    minus_r    <= minus_nxt;
    zflag_r    <= zflag_nxt;
    dot_r      <= dot_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    b3_r       <= b3_nxt;
    total_r    <= total_nxt;
    pad_zero_r <= pad_zero_nxt;
    out_data_r <= out_data_nxt;
  end

  // The emit position never runs past the end of the run.
  `ASSERT_IMPLIES(a_pos_in_run, clk, rst_n, state_r == ST_EMIT, pos_r < total_r, "emit position past run length")
  // After stripping, a nonzero digit count starts with a nonzero digit.
  `ASSERT_IMPLIES(a_lead_digit, clk, rst_n, (state_r == ST_SETUP) && (ndig_r != '0), !top_zero, "leading digit is zero")
  // The digit being printed is always a valid decimal digit.
  `ASSERT_IMPLIES(a_bcd_digit, clk, rst_n, state_r == ST_EMIT, bcd_r[BCD_W-1 -: 4] <= 4'd9, "digit out of range")
  // Conversion ends once the bit counter has covered every value bit.
  `ASSERT_NEXT(a_conv_len, clk, rst_n, (state_r == ST_CONV) && (bit_cnt_r == '1), state_r == ST_NORM, "conversion did not end")

endmodule
